@@ hdl/bpfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the bitmap page frame allocator.
// No dependencies.

package bpfa_pkg;

    localparam int ACTION_W        = 2;
    localparam int IDX_W           = 16;
    localparam int CNT_W           = 17;
    localparam int FRAME_W         = 17;
    localparam int STATUS_W        = 2;
    localparam int WORD_W          = 32;
    localparam int BIT_W           = 5;
    localparam int PC_W            = 6;
    localparam int WP_W            = FRAME_W - BIT_W;
    localparam int FRAME_LIMIT_DEF = 65536;
    localparam logic [FRAME_W-1:0] CFG_RESET = FRAME_W'(65536);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_USABLE  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE   = 2'd0,
        STS_OOM    = 2'd1,
        STS_REJECT = 2'd2,
        STS_DOUBLE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESERVE,
        OP_USABLE,
        OP_RECOUNT
    } op_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [WORD_W-1:0] new_word;
        logic [PC_W-1:0]   pc;
        logic              found;
        logic [BIT_W-1:0]  found_bit;
    } word_res_t;

    // bits [n-1:0] set, n up to 32
    function automatic logic [WORD_W-1:0] lowmask(input logic [PC_W-1:0] n);
        return ~({WORD_W{1'b1}} << n);
    endfunction

    function automatic logic [PC_W-1:0] popcount32(input logic [WORD_W-1:0] v);
        logic [1:0] l1 [16];
        logic [2:0] l2 [8];
        logic [3:0] l3 [4];
        logic [4:0] l4 [2];
        for (int i = 0; i < 16; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        return {1'b0, l4[0]} + {1'b0, l4[1]};
    endfunction

endpackage

@@ hdl/bpfa_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the page frame allocator: valid/ready plus the request fields.
// Depends on bpfa_pkg.

interface bpfa_req_if;
    logic                           valid;
    logic                           ready;
    logic [bpfa_pkg::ACTION_W-1:0] action;
    logic [bpfa_pkg::IDX_W-1:0]    frame_index;
    logic [bpfa_pkg::CNT_W-1:0]    frame_count;

    modport source (output valid, action, frame_index, frame_count, input ready);
    modport sink   (input valid, action, frame_index, frame_count, output ready);
endinterface

@@ hdl/bpfa_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the page frame allocator: valid/ready plus the result fields.
// Depends on bpfa_pkg.

interface bpfa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bpfa_pkg::IDX_W-1:0]    result_frame;
    logic [bpfa_pkg::STATUS_W-1:0] status;
    logic [bpfa_pkg::FRAME_W-1:0]  free_count;
    logic [bpfa_pkg::FRAME_W-1:0]  used_count;

    modport source (output valid, result_frame, status, free_count, used_count, input ready);
    modport sink   (input valid, result_frame, status, free_count, used_count, output ready);
endinterface

@@ hdl/bpfa_word_unit.sv @@
`timescale 1ns / 1ps
// Shared per-word unit: range mask, bit update, first-free search and popcount of
// the changed (or counted) bits of one 32-bit map word. Depends on bpfa_pkg.

module bpfa_word_unit (
    input  bpfa_pkg::op_t                   op,
    input  logic [bpfa_pkg::WORD_W-1:0]     data,
    input  logic [bpfa_pkg::FRAME_W-1:0]    base,
    input  logic [bpfa_pkg::FRAME_W-1:0]    s,
    input  logic [bpfa_pkg::FRAME_W-1:0]    e,
    input  logic                            is_word0,
    output bpfa_pkg::word_res_t             res
);

    logic [bpfa_pkg::FRAME_W-1:0] hi_d;
    logic [bpfa_pkg::FRAME_W-1:0] lo_d;
    logic [bpfa_pkg::PC_W-1:0]    hi_n;
    logic [bpfa_pkg::PC_W-1:0]    lo_n;
    logic [bpfa_pkg::WORD_W-1:0]  mask;
    logic [bpfa_pkg::WORD_W-1:0]  w0;
    logic [bpfa_pkg::WORD_W-1:0]  avail;
    logic [bpfa_pkg::WORD_W-1:0]  onehot;
    logic [bpfa_pkg::WORD_W-1:0]  changed;
    logic [bpfa_pkg::BIT_W-1:0]   fb;

    always_comb
    begin
        hi_d = e - base;
        lo_d = s - base;
        hi_n = (hi_d >= bpfa_pkg::FRAME_W'(bpfa_pkg::WORD_W)) ?
               bpfa_pkg::PC_W'(bpfa_pkg::WORD_W) : hi_d[bpfa_pkg::PC_W-1:0];
        lo_n = (s > base) ? lo_d[bpfa_pkg::PC_W-1:0] : '0;
        mask = bpfa_pkg::lowmask(hi_n) & ~bpfa_pkg::lowmask(lo_n);

        // frame 0 is never handed out; a free frame 0 is simply marked used
        w0     = {{(bpfa_pkg::WORD_W-1){1'b0}}, is_word0 & ~data[0] & mask[0]};
        avail  = ~data & mask & ~{{(bpfa_pkg::WORD_W-1){1'b0}}, is_word0};
        onehot = avail & (~avail + bpfa_pkg::WORD_W'(1));
        fb     = '0;
        for (int i = bpfa_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (avail[i])
                fb = bpfa_pkg::BIT_W'(i);
        end

        case (op) inside
            bpfa_pkg::OP_FREE, bpfa_pkg::OP_USABLE:
            begin
                changed      = data & mask;
                res.new_word = data & ~changed;
            end
            bpfa_pkg::OP_ALLOC:
            begin
                changed      = w0 | onehot;
                res.new_word = data | changed;
            end
            default:
            begin
                changed      = ~data & mask;
                res.new_word = data | changed;
            end
        endcase

        res.pc        = bpfa_pkg::popcount32(changed);
        res.found     = |avail;
        res.found_bit = fb;
    end

endmodule

@@ hdl/bitmap_page_frame_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the bitmap page frame allocator: map memory, sequencer, channels.
// Depends on bpfa_pkg, bpfa_req_if, bpfa_rsp_if and bpfa_word_unit.
//
// Usage:
//  req carries action, frame_index and frame_count; one transfer is one request.
//  rsp returns exactly one result per request: frame, status, free and used counts.
//  cfg_wr_en/cfg_wr_data write the covered frame total; the free count is then
//  recounted by a pass over the covered map words before the next request is taken.
//  After reset the map is cleared to all used by a pass over every map word, during
//  which req.ready stays low; config writes are taken.
//  One map word is read per cycle through the shared word unit. Allocation scans
//  from word 0 and stops at the first word with a free frame; a single free reads
//  one word; a range reads each word it covers; rejected or empty requests skip
//  the scan. Each scan goes through the word unit and the single map read port.
//  Requests are handled one at a time. The result sits in an output register; a
//  stalled rsp holds it and the next request is taken and worked on meanwhile, its
//  result waiting until the register is free.

module bitmap_page_frame_allocator #(
    parameter int FRAME_LIMIT = bpfa_pkg::FRAME_LIMIT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bpfa_pkg::FRAME_W-1:0]  cfg_wr_data,
    bpfa_req_if.sink                      req,
    bpfa_rsp_if.source                    rsp
);

    localparam int MAP_WORDS = (FRAME_LIMIT + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CLR_W     = $clog2(MAP_WORDS + 1);
    localparam int FW        = bpfa_pkg::FRAME_W;
    localparam int WPW       = bpfa_pkg::WP_W;

    bpfa_pkg::fsm_t state_reg, state_next;

    logic [FW-1:0]    cfg_reg;
    logic             pend_reg, pend_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [FW-1:0]    free_reg, free_next;
    logic             issuing_reg, issuing_next;
    logic             pv_reg, pv_next;
    logic             rsp_valid_reg, rsp_valid_next;

    bpfa_pkg::op_t     op_reg, op_next;
    bpfa_pkg::status_t jstat_reg, jstat_next;
    logic [FW-1:0]     s_reg, s_next;
    logic [FW-1:0]     e_reg, e_next;
    logic [WPW-1:0]    iw_reg, iw_next;
    logic [WPW-1:0]    pw_reg, pw_next;
    logic [FW-1:0]     jres_reg, jres_next;

    logic [bpfa_pkg::IDX_W-1:0]    rsp_frame_reg, rsp_frame_next;
    logic [bpfa_pkg::STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [FW-1:0]                 rsp_free_reg, rsp_free_next;
    logic [FW-1:0]                 rsp_used_reg, rsp_used_next;

    logic [bpfa_pkg::WORD_W-1:0] mem [MAP_WORDS];
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [bpfa_pkg::WORD_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [bpfa_pkg::WORD_W-1:0] mem_rdata;

    logic [FW-1:0]       t;
    logic                accept;
    logic                load;
    logic                scan_end;
    logic [WPW:0]        iw_inc;
    logic [FW:0]         rng_sum;
    logic [FW-1:0]       rng_end;
    logic [FW-1:0]       idx_ext;
    bpfa_pkg::op_t       d_op;
    logic [FW-1:0]       d_s;
    logic [FW-1:0]       d_e;
    logic                d_direct;
    bpfa_pkg::status_t   d_stat;
    bpfa_pkg::word_res_t wres;

    assign t = (32'(cfg_reg) > 32'(FRAME_LIMIT)) ? FW'(FRAME_LIMIT) : cfg_reg;

    assign req.ready = (state_reg == bpfa_pkg::S_IDLE) && !pend_reg;
    assign accept    = req.valid && req.ready;
    assign load      = (state_reg == bpfa_pkg::S_DONE) && (!rsp_valid_reg || rsp.ready);
    assign scan_end  = !issuing_reg && !pv_reg;
    assign iw_inc    = {1'b0, iw_reg} + (WPW+1)'(1);

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_frame = rsp_frame_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.free_count   = rsp_free_reg;
    assign rsp.used_count   = rsp_used_reg;

    bpfa_word_unit u_word (
        .op       (op_reg),
        .data     (mem_rdata),
        .base     ({pw_reg, {bpfa_pkg::BIT_W{1'b0}}}),
        .s        (s_reg),
        .e        (e_reg),
        .is_word0 (pw_reg == '0),
        .res      (wres)
    );

    // request decode
    always_comb
    begin
        idx_ext = FW'(req.frame_index);
        rng_sum = {1'b0, idx_ext} + (FW+1)'(req.frame_count);
        rng_end = (rng_sum > {1'b0, t}) ? t : rng_sum[FW-1:0];
        unique case (bpfa_pkg::action_t'(req.action))
            bpfa_pkg::ACT_ALLOC:
            begin
                d_op     = bpfa_pkg::OP_ALLOC;
                d_s      = '0;
                d_e      = t;
                d_direct = (t == '0);
                d_stat   = bpfa_pkg::STS_OOM;
            end
            bpfa_pkg::ACT_FREE:
            begin
                d_op     = bpfa_pkg::OP_FREE;
                d_s      = idx_ext;
                d_e      = idx_ext + FW'(1);
                d_direct = (idx_ext == '0) || (idx_ext >= t);
                d_stat   = bpfa_pkg::STS_REJECT;
            end
            bpfa_pkg::ACT_RESERVE:
            begin
                d_op     = bpfa_pkg::OP_RESERVE;
                d_s      = idx_ext;
                d_e      = rng_end;
                d_direct = (rng_end <= idx_ext);
                d_stat   = bpfa_pkg::STS_DONE;
            end
            default:
            begin
                d_op     = bpfa_pkg::OP_USABLE;
                d_s      = idx_ext;
                d_e      = rng_end;
                d_direct = (rng_end <= idx_ext);
                d_stat   = bpfa_pkg::STS_DONE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpfa_pkg::S_CLEAR:
            begin
                if (clr_reg == CLR_W'(MAP_WORDS - 1))
                    state_next = bpfa_pkg::S_IDLE;
            end
            bpfa_pkg::S_IDLE:
            begin
                if (pend_reg)
                    state_next = (t == '0) ? bpfa_pkg::S_IDLE : bpfa_pkg::S_SCAN;
                else if (accept)
                    state_next = d_direct ? bpfa_pkg::S_DONE : bpfa_pkg::S_SCAN;
            end
            bpfa_pkg::S_SCAN:
            begin
                if (pv_reg && (op_reg == bpfa_pkg::OP_ALLOC) && wres.found)
                    state_next = bpfa_pkg::S_DONE;
                else if (scan_end)
                    state_next = (op_reg == bpfa_pkg::OP_RECOUNT) ?
                                 bpfa_pkg::S_IDLE : bpfa_pkg::S_DONE;
            end
            bpfa_pkg::S_DONE:
            begin
                if (load)
                    state_next = bpfa_pkg::S_IDLE;
            end
            default:
                state_next = bpfa_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        pend_next       = cfg_wr_en ? 1'b1 : pend_reg;
        clr_next        = clr_reg;
        free_next       = free_reg;
        issuing_next    = issuing_reg;
        pv_next         = pv_reg;
        op_next         = op_reg;
        jstat_next      = jstat_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        iw_next         = iw_reg;
        pw_next         = pw_reg;
        jres_next       = jres_reg;
        rsp_frame_next  = rsp_frame_reg;
        rsp_status_next = rsp_status_reg;
        rsp_free_next   = rsp_free_reg;
        rsp_used_next   = rsp_used_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = AW'(pw_reg);
        mem_wdata       = wres.new_word;
        mem_raddr       = AW'(iw_reg);

        unique case (state_reg)
            bpfa_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                mem_wdata = '1;
                clr_next  = clr_reg + CLR_W'(1);
            end
            bpfa_pkg::S_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next    = cfg_wr_en;
                    op_next      = bpfa_pkg::OP_RECOUNT;
                    s_next       = '0;
                    e_next       = t;
                    free_next    = '0;
                    iw_next      = '0;
                    issuing_next = 1'b1;
                    pv_next      = 1'b0;
                end
                else if (accept)
                begin
                    op_next      = d_op;
                    s_next       = d_s;
                    e_next       = d_e;
                    iw_next      = d_s[FW-1:bpfa_pkg::BIT_W];
                    issuing_next = 1'b1;
                    pv_next      = 1'b0;
                    jres_next    = '0;
                    jstat_next   = d_direct ? d_stat : bpfa_pkg::STS_DONE;
                end
            end
            bpfa_pkg::S_SCAN:
            begin
                if (issuing_reg)
                begin
                    iw_next      = iw_inc[WPW-1:0];
                    issuing_next = {iw_inc, {bpfa_pkg::BIT_W{1'b0}}} < {1'b0, e_reg};
                    pv_next      = 1'b1;
                    pw_next      = iw_reg;
                end
                else
                    pv_next = 1'b0;

                if (pv_reg)
                begin
                    mem_we = (op_reg != bpfa_pkg::OP_RECOUNT);
                    if ((op_reg == bpfa_pkg::OP_FREE) || (op_reg == bpfa_pkg::OP_USABLE) ||
                        (op_reg == bpfa_pkg::OP_RECOUNT))
                        free_next = free_reg + FW'(wres.pc);
                    else
                        free_next = free_reg - FW'(wres.pc);
                    if ((op_reg == bpfa_pkg::OP_ALLOC) && wres.found)
                        jres_next = {pw_reg, wres.found_bit};
                    if ((op_reg == bpfa_pkg::OP_FREE) && (wres.pc == '0))
                        jstat_next = bpfa_pkg::STS_DOUBLE;
                end
                else if (scan_end && (op_reg == bpfa_pkg::OP_ALLOC))
                    jstat_next = bpfa_pkg::STS_OOM;
            end
            bpfa_pkg::S_DONE:
            begin
                if (load)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_frame_next  = jres_reg[bpfa_pkg::IDX_W-1:0];
                    rsp_status_next = jstat_reg;
                    rsp_free_next   = free_reg;
                    rsp_used_next   = t - free_reg;
                end
            end
            default:
            begin
                pv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpfa_pkg::S_CLEAR;
            cfg_reg       <= bpfa_pkg::CFG_RESET;
            pend_reg      <= 1'b0;
            clr_reg       <= '0;
            free_reg      <= '0;
            issuing_reg   <= 1'b0;
            pv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
            pend_reg      <= pend_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            issuing_reg   <= issuing_next;
            pv_reg        <= pv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        jstat_reg      <= jstat_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        iw_reg         <= iw_next;
        pw_reg         <= pw_next;
        jres_reg       <= jres_next;
        rsp_frame_reg  <= rsp_frame_next;
        rsp_status_reg <= rsp_status_next;
        rsp_free_reg   <= rsp_free_next;
        rsp_used_reg   <= rsp_used_next;
    end

    // used-bit map, at most one word written and one read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

endmodule

@@ test/tb_bitmap_page_frame_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of bitmap_page_frame_allocator: directed and random requests,
// a frame map predictor and a field-by-field response scoreboard.
// Depends on bpfa_pkg, bpfa_req_if, bpfa_rsp_if and the allocator RTL.

module tb_bitmap_page_frame_allocator;

    localparam int NUM_FRAMES  = 65536;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE      = 40;

    typedef struct packed {
        bpfa_pkg::action_t action;
        logic [15:0]       frame_index;
        logic [16:0]       frame_count;
    } frame_req_t;

    typedef struct packed {
        logic [15:0]       frame;
        bpfa_pkg::status_t status;
        logic [16:0]       free_cnt;
        logic [16:0]       used_cnt;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;

    bpfa_req_if req_ch();
    bpfa_rsp_if rsp_ch();

    bitmap_page_frame_allocator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // predictor state
    bit          frame_used [NUM_FRAMES];
    int unsigned cover_total;
    int unsigned spare_frames;

    frame_req_t    pending_reqs [$];
    alloc_result_t expected_results [$];

    bit          req_taken;
    bit          no_gaps;
    int          mismatches;
    int          results_checked;
    int          requests_taken;
    int          totals_written;
    int unsigned cycle_count;

    function automatic int unsigned clip_total(logic [16:0] v);
        return (v > NUM_FRAMES) ? NUM_FRAMES : int'(v);
    endfunction

    function automatic void mark_used(int unsigned f);
        if (f < NUM_FRAMES && !frame_used[f])
        begin
            frame_used[f] = 1'b1;
            spare_frames--;
        end
    endfunction

    function automatic void mark_free(int unsigned f);
        if (f < NUM_FRAMES && frame_used[f])
        begin
            frame_used[f] = 1'b0;
            spare_frames++;
        end
    endfunction

    function automatic void set_total(logic [16:0] v);
        cover_total = clip_total(v);
        spare_frames = 0;
        for (int unsigned f = 0; f < cover_total; f++)
            if (!frame_used[f])
                spare_frames++;
    endfunction

    function automatic int unsigned lowest_free();
        for (int unsigned f = 0; f < cover_total; f++)
            if (!frame_used[f])
                return f;
        return cover_total;
    endfunction

    function automatic alloc_result_t predict_request(frame_req_t r);
        alloc_result_t res;
        int unsigned   f;
        int unsigned   last;
        res.frame  = '0;
        res.status = bpfa_pkg::STS_DONE;
        case (r.action)
            bpfa_pkg::ACT_ALLOC:
            begin
                f = lowest_free();
                if (f == 0 && f < cover_total)
                begin
                    mark_used(0);
                    f = lowest_free();
                end
                if (f < cover_total)
                begin
                    mark_used(f);
                    res.frame = f[15:0];
                end
                else
                    res.status = bpfa_pkg::STS_OOM;
            end
            bpfa_pkg::ACT_FREE:
            begin
                if (r.frame_index == 0 || r.frame_index >= cover_total)
                    res.status = bpfa_pkg::STS_REJECT;
                else if (!frame_used[r.frame_index])
                    res.status = bpfa_pkg::STS_DOUBLE;
                else
                    mark_free(r.frame_index);
            end
            default:
            begin
                last = int'(r.frame_index) + int'(r.frame_count);
                if (last > cover_total)
                    last = cover_total;
                for (f = r.frame_index; f < last; f++)
                begin
                    if (r.action == bpfa_pkg::ACT_RESERVE)
                        mark_used(f);
                    else
                        mark_free(f);
                end
            end
        endcase
        res.free_cnt = spare_frames[16:0];
        res.used_cnt = 17'(cover_total - spare_frames);
        return res;
    endfunction

    function automatic frame_req_t random_request(int unsigned t);
        frame_req_t  r;
        int unsigned pick;
        int unsigned hot;
        hot  = (t < 64) ? t : 64;
        pick = $urandom_range(0, 99);
        r.frame_index = 16'($urandom());
        r.frame_count = 17'($urandom());
        if (pick < 30)
            r.action = bpfa_pkg::ACT_ALLOC;
        else if (pick < 55)
        begin
            r.action = bpfa_pkg::ACT_FREE;
            if ($urandom_range(0, 3) == 0)
                r.frame_index = 16'($urandom_range(0, (t + 1 > 65535) ? 65535 : t + 1));
            else
                r.frame_index = 16'($urandom_range(0, hot + 2));
        end
        else if (pick < 75)
        begin
            r.action      = bpfa_pkg::ACT_USABLE;
            r.frame_index = 16'($urandom_range(0, hot));
            r.frame_count = 17'($urandom_range(0, 40));
        end
        else if (pick < 88)
        begin
            r.action      = bpfa_pkg::ACT_RESERVE;
            r.frame_index = 16'($urandom_range(0, hot));
            r.frame_count = 17'($urandom_range(0, 24));
        end
        else
            r.action = bpfa_pkg::action_t'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic push_req(bpfa_pkg::action_t a, int unsigned idx, int unsigned cnt);
        pending_reqs.push_back('{a, 16'(idx), 17'(cnt)});
    endtask

    // checked at the rising edge, where the driver's updates have settled
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(logic [16:0] total, int n_random, bit gapless);
        wait_drained();
        repeat (4) @(negedge clk);
        no_gaps     <= gapless;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= total;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        totals_written++;
        for (int i = 0; i < n_random; i++)
            pending_reqs.push_back(random_request(clip_total(total)));
    endtask

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // request driver
    always @(negedge clk)
    begin : drive_req
        frame_req_t next_req;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 11))
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= next_req.action;
                    req_ch.frame_index <= next_req.frame_index;
                    req_ch.frame_count <= next_req.frame_count;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 11);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin : monitor
        alloc_result_t want;
        req_taken <= req_ch.valid && req_ch.ready;
        if (cfg_wr_en)
            set_total(cfg_wr_data);
        if (req_ch.valid && req_ch.ready)
        begin
            expected_results.push_back(predict_request('{bpfa_pkg::action_t'(req_ch.action),
                                        req_ch.frame_index, req_ch.frame_count}));
            requests_taken++;
        end
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with nothing outstanding: frame %0d status %0d",
                             $realtime, rsp_ch.result_frame, rsp_ch.status);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (rsp_ch.result_frame !== want.frame || rsp_ch.status !== want.status ||
                    rsp_ch.free_count !== want.free_cnt || rsp_ch.used_count !== want.used_cnt)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch exp frame %0d st %0d free %0d used %0d",
                                 $realtime, want.frame, want.status, want.free_cnt,
                                 want.used_cnt);
                        $display("    got frame %0d st %0d free %0d used %0d",
                                 rsp_ch.result_frame, rsp_ch.status,
                                 rsp_ch.free_count, rsp_ch.used_count);
                    end
                end
            end
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = bpfa_pkg::ACT_ALLOC;
        req_ch.frame_index = '0;
        req_ch.frame_count = '0;
        rsp_ch.ready       = 1'b0;
        req_taken          = 1'b0;
        no_gaps            = 1'b0;
        mismatches         = 0;
        results_checked    = 0;
        requests_taken     = 0;
        totals_written     = 0;
        cycle_count        = 0;
        for (int f = 0; f < NUM_FRAMES; f++)
            frame_used[f] = 1'b1;
        spare_frames = 0;
        cover_total = clip_total(bpfa_pkg::CFG_RESET);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: map starts fully used
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_FREE, 0, 0);
        push_req(bpfa_pkg::ACT_FREE, 65535, 0);
        push_req(bpfa_pkg::ACT_FREE, 65535, 0);
        push_req(bpfa_pkg::ACT_USABLE, 0, 40);
        push_req(bpfa_pkg::ACT_ALLOC, 65535, 131071);
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_FREE, 1, 0);
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_RESERVE, 0, 0);
        push_req(bpfa_pkg::ACT_USABLE, 65535, 131071);
        push_req(bpfa_pkg::ACT_RESERVE, 65520, 131071);
        push_req(bpfa_pkg::ACT_USABLE, 0, 65536);
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_RESERVE, 0, 65536);
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_USABLE, 0, 1);
        push_req(bpfa_pkg::ACT_ALLOC, 0, 0);
        push_req(bpfa_pkg::ACT_USABLE, 8, 24);
        push_req(bpfa_pkg::ACT_FREE, 65534, 0);
        for (int i = 0; i < 30; i++)
            pending_reqs.push_back(random_request(cover_total));

        run_phase(17'd300, 60, 1'b0);
        run_phase(17'd0, 15, 1'b0);
        run_phase(17'd1, 15, 1'b0);
        run_phase(17'd33, 40, 1'b0);
        run_phase(17'd131071, 25, 1'b0);
        run_phase(17'd2000, 50, 1'b1);
        run_phase(17'd32, 30, 1'b0);
        run_phase(17'd65536, 25, 1'b0);

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            mismatches += expected_results.size();
            $display("%0d responses never arrived", expected_results.size());
        end
        $display("Ran %0d requests over %0d frame totals, %0d responses compared.",
                 requests_taken, totals_written + 1, results_checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
